[hw/rtl/kmp_stream_matcher_core_defines.svh]
// Assertion macros shared by the KMP stream matcher RTL.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef KMP_STREAM_MATCHER_CORE_DEFINES_SVH
`define KMP_STREAM_MATCHER_CORE_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define KMP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the same cycle.
`define KMP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/kmp_pkg.sv]
// Shared types for the KMP stream matcher: controller commands and datapath status.
// No dependencies.
`default_nettype none

package kmp_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic step;      // follow one fallback link
    logic finish;    // commit the scan result
    logic out_load;  // load the result register
  } kmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_cmp;    // accepted item needs a compare phase
    logic follow;    // mismatch with nonzero length: follow a link
    logic res_valid; // finishing item produces a result
  } kmp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/kmp_dp.sv]
// Datapath of the KMP stream matcher: pattern store, fallback table, match state.
// Depends on kmp_pkg and kmp_stream_matcher_core_defines.svh.
`default_nettype none
`include "kmp_stream_matcher_core_defines.svh"

module kmp_dp #(
  parameter int MAX_PATTERN    = 64,
  parameter int POSITION_WIDTH = 32
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic kind,
  input  wire                logic [7:0] data_byte,
  input  wire                logic last,
  input  wire kmp_pkg::kmp_cmd_t cmd,
  output kmp_pkg::kmp_stat_t stat,
  output logic               found,
  output logic [31:0]        match_position,
  output logic               pattern_truncated
);
  import kmp_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PW = POSITION_WIDTH;
  localparam int CW = (PW > LW) ? PW : LW;
  localparam int OW = (PW > 32) ? PW : 32;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);
  localparam logic [PW-1:0] POS_MAX = '1;
  localparam logic KIND_TEXT = 1'b1;

  logic [7:0]    pat_mem [MAX_PATTERN];
  logic [LW-1:0] fb_mem  [MAX_PATTERN];
  logic [7:0]    pat_q;
  logic [LW-1:0] fb_q;

  logic [LW-1:0] plen, mlen, k, fb_last;
  logic [PW-1:0] pos, idx;
  logic          any_found, trunc, closed;
  logic [7:0]    b_q;
  logic          last_q, kind_q;

  logic          restart, is_text, eq, hit, none, has_pat, rd_en, lt;
  logic [LW-1:0] i_eff, k_init, rd_k, rd_km1, k_new, m1;
  logic [AW-1:0] pat_addr, fb_addr, pat_wa, fb_wa;
  logic          pat_we, fb_we;
  logic [LW-1:0] fb_wd;
  logic [CW-1:0] idx_w, m1_w;
  logic [PW-1:0] start;
  logic [OW-1:0] start_o;

  always_comb begin
    is_text  = (kind == KIND_TEXT);
    restart  = closed;
    i_eff    = restart ? '0 : plen;
    k_init   = is_text ? ((mlen >= plen) ? '0 : mlen) : fb_last;
    rd_k     = cmd.accept ? k_init : fb_q;
    rd_km1   = rd_k - LW'(1);
    rd_en    = cmd.accept | cmd.step;
    pat_addr = rd_k[AW-1:0];
    fb_addr  = rd_km1[AW-1:0];

    eq      = (b_q == pat_q);
    has_pat = (kind_q != KIND_TEXT) || (plen != '0);
    k_new   = k + LW'(eq);
    hit     = (kind_q == KIND_TEXT) && (plen != '0) && (k_new == plen);
    none    = (kind_q == KIND_TEXT) && !hit && last_q && !any_found;

    m1      = plen - LW'(1);
    idx_w   = CW'(idx);
    m1_w    = CW'(m1);
    lt      = idx_w < m1_w;
    start   = ((idx == POS_MAX) || lt) ? idx : idx - m1_w[PW-1:0];
    start_o = OW'(start);

    pat_we = cmd.accept && !is_text && (i_eff < MAX_LEN);
    pat_wa = i_eff[AW-1:0];
    fb_we  = (cmd.accept && !is_text && (i_eff == '0)) ||
             (cmd.finish && (kind_q != KIND_TEXT));
    fb_wa  = cmd.finish ? plen[AW-1:0] : '0;
    fb_wd  = cmd.finish ? k_new : '0;

    stat.go_cmp    = is_text || ((i_eff != '0) && (i_eff < MAX_LEN));
    stat.follow    = has_pat && (k != '0) && !eq;
    stat.res_valid = hit || none;
  end

  // Memories: registered reads, single write port each.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pat_q <= pat_mem[pat_addr];
      fb_q  <= fb_mem[fb_addr];
    end
    if (pat_we) begin
      pat_mem[pat_wa] <= data_byte;
    end
    if (fb_we) begin
      fb_mem[fb_wa] <= fb_wd;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      plen      <= '0;
      mlen      <= '0;
      pos       <= '0;
      any_found <= 1'b0;
      trunc     <= 1'b0;
      closed    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (is_text) begin
          closed <= 1'b1;
          if (pos != POS_MAX) begin
            pos <= pos + PW'(1);
          end
        end else begin
          if (restart) begin
            trunc     <= 1'b0;
            mlen      <= '0;
            pos       <= '0;
            any_found <= 1'b0;
          end
          closed <= last;
          if (i_eff >= MAX_LEN) begin
            trunc <= 1'b1;
          end else if (i_eff == '0) begin
            plen <= LW'(1);
          end
        end
      end
      if (cmd.finish) begin
        if (kind_q == KIND_TEXT) begin
          if (last_q) begin
            mlen      <= '0;
            pos       <= '0;
            any_found <= 1'b0;
          end else begin
            if (plen != '0) begin
              mlen <= hit ? fb_last : k_new;
            end
            if (hit) begin
              any_found <= 1'b1;
            end
          end
        end else begin
          plen <= plen + LW'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k      <= k_init;
      b_q    <= data_byte;
      last_q <= last;
      kind_q <= kind;
      idx    <= pos;
      if (!is_text && (i_eff == '0)) begin
        fb_last <= '0;
      end
    end else if (cmd.step) begin
      k <= fb_q;
    end
    if (cmd.finish && (kind_q != KIND_TEXT)) begin
      fb_last <= k_new;
    end
    if (cmd.out_load) begin
      found             <= hit;
      match_position    <= hit ? start_o[31:0] : 32'd0;
      pattern_truncated <= trunc;
    end
  end

  `KMP_ASSERT_ALWAYS(a_mlen_below_plen, (mlen == '0) || (mlen < plen), "match length too big")
  `KMP_ASSERT_IMPLIES(a_fb_last_below_plen, plen != '0, fb_last < plen, "bad last link")
  `KMP_ASSERT_ALWAYS(a_plen_bound, plen <= MAX_LEN, "pattern length beyond store size")

endmodule

`default_nettype wire

[hw/rtl/kmp_ctrl.sv]
// Controller of the KMP stream matcher: sequences accept, link following and result.
// Depends on kmp_pkg and kmp_stream_matcher_core_defines.svh.
`default_nettype none
`include "kmp_stream_matcher_core_defines.svh"

module kmp_ctrl (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic item_valid,
  output logic               item_stall,
  output logic               result_valid,
  input  wire                logic result_stall,
  output kmp_pkg::kmp_cmd_t  cmd,
  input  wire kmp_pkg::kmp_stat_t stat
);
  import kmp_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_CMP
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;

  always_comb begin
    cmd               = '0;
    state_next        = state;
    result_valid_next = result_valid && result_stall;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (stat.go_cmp) begin
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (stat.follow) begin
          cmd.step = 1'b1;
        end else if (!(stat.res_valid && result_valid && result_stall)) begin
          // an item with a result holds here while a stalled result still occupies the register
          cmd.finish = 1'b1;
          state_next = S_IDLE;
          if (stat.res_valid) begin
            cmd.out_load      = 1'b1;
            result_valid_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  `KMP_ASSERT_IMPLIES(a_no_overwrite, result_valid && result_stall, !cmd.out_load, "overwrite")
  `KMP_ASSERT_NEXT(a_enter_cmp, cmd.accept && stat.go_cmp, state == S_CMP, "no compare phase")
  `KMP_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.accept, cmd.step, cmd.finish}), "conflicting commands")

endmodule

`default_nettype wire

[hw/rtl/kmp_stream_matcher_core.sv]
// Top level of the KMP stream matcher: joins controller and datapath.
// Depends on kmp_pkg, kmp_ctrl and kmp_dp.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------
//   item    | in        | item_valid / item_stall    | kind, data_byte, last
//   result  | out       | result_valid / result_stall| found, match_position, pattern_truncated
//
// Sequencing: a text or pattern byte is accepted, then a compare phase follows fallback links
//   and commits; the first pattern byte, dropped pattern bytes and a restart byte skip it.
//   The loop over fallback links makes one registered table read per cycle.
// Reset: rst clears lengths, flags and position; the pattern store and fallback
//   table are not cleared, and their contents are only used below the loaded pattern length.
// Stalls: a result waits in its output register; a new item is taken meanwhile, and
//   only an item that itself produces a result holds until that register drains.
`default_nettype none

module kmp_stream_matcher_core #(
  parameter int MAX_PATTERN    = 64,
  parameter int POSITION_WIDTH = 32
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  // item channel
  input  wire  logic        item_valid,
  output logic              item_stall,
  input  wire  logic        kind,
  input  wire  logic [7:0]  data_byte,
  input  wire  logic        last,
  // result channel
  output logic              result_valid,
  input  wire  logic        result_stall,
  output logic              found,
  output logic [31:0]       match_position,
  output logic              pattern_truncated
);
  import kmp_pkg::*;

  kmp_cmd_t  cmd;
  kmp_stat_t stat;

  // Sequence each transfer: accept, follow links, commit and load the result.
  kmp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Hold the pattern, fallback links, match length and position.
  kmp_dp #(
    .MAX_PATTERN    (MAX_PATTERN),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .kind              (kind),
    .data_byte         (data_byte),
    .last              (last),
    .cmd               (cmd),
    .stat              (stat),
    .found             (found),
    .match_position    (match_position),
    .pattern_truncated (pattern_truncated)
  );

endmodule

`default_nettype wire

[bench/kmp_match_checker.sv]
// Scoreboard for the KMP stream matcher: tracks item and result transfers, predicts
// every result from its own copy of the matcher state and compares field by field.
// Depends on nothing but the port list of kmp_stream_matcher_core.
`timescale 1ns / 100ps

package kmp_bench_pkg;
  typedef enum logic {
    KIND_PATTERN = 1'b0,
    KIND_TEXT    = 1'b1
  } item_kind_e;

  localparam int STORE_DEPTH = 64;
endpackage

module kmp_match_checker
  import kmp_bench_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire logic        item_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  input  wire logic        result_valid,
  input  wire logic        result_stall,
  input  wire logic        found,
  input  wire logic [31:0] match_position,
  input  wire logic        pattern_truncated,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic        truncated;
  } match_report_t;

  logic [7:0]    pat_mem   [STORE_DEPTH];
  logic [6:0]    fail_link [STORE_DEPTH];
  int            pat_len;
  int            run_len;
  logic [31:0]   text_pos;
  bit            any_hit;
  bit            trunc_flag;
  bit            pat_closed;
  match_report_t report_q [$];

  function automatic void clear_text();
    run_len  = 0;
    text_pos = '0;
    any_hit  = 1'b0;
  endfunction

  // Append one byte and extend the failure table; drop it once the store is full.
  function automatic void load_pattern(logic [7:0] b);
    int i;
    int k;
    i = pat_len;
    if (i >= STORE_DEPTH) begin
      trunc_flag = 1'b1;
      return;
    end
    pat_mem[i] = b;
    k = 0;
    if (i > 0) begin
      k = fail_link[i - 1];
      while (k > 0 && b != pat_mem[k]) k = fail_link[k - 1];
      if (b == pat_mem[k]) k++;
    end
    fail_link[i] = 7'(k);
    pat_len = i + 1;
  endfunction

  // Advance the scan by one text byte; return 1 when the byte yields a result.
  function automatic bit scan_text(logic [7:0] b, logic is_last, output match_report_t rep);
    logic [31:0] idx;
    logic [31:0] start;
    int          k;
    bit          hit;
    bit          none;
    hit        = 1'b0;
    start      = '0;
    rep        = '0;
    pat_closed = 1'b1;
    idx        = text_pos;
    if (text_pos != '1) text_pos++;
    if (pat_len > 0) begin
      k = (run_len >= pat_len) ? 0 : run_len;
      while (k > 0 && b != pat_mem[k]) k = fail_link[k - 1];
      if (b == pat_mem[k]) k++;
      if (k == pat_len) begin
        hit   = 1'b1;
        start = (idx == '1 || idx < 32'(pat_len - 1)) ? idx : idx - 32'(pat_len - 1);
        k     = fail_link[pat_len - 1];
      end
      run_len = k;
    end
    if (hit) begin
      any_hit = 1'b1;
      rep = '{found: 1'b1, start: start, truncated: trunc_flag};
      if (is_last) clear_text();
      return 1'b1;
    end
    if (is_last) begin
      none = !any_hit;
      clear_text();
      if (none) begin
        rep = '{found: 1'b0, start: '0, truncated: trunc_flag};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    match_report_t want;
    match_report_t got;
    if (rst) begin
      pat_len    = 0;
      trunc_flag = 1'b0;
      pat_closed = 1'b0;
      clear_text();
      report_q.delete();
    end else begin
      // Check the outgoing transfer first: a result never belongs to an item taken
      // at the same edge.
      if (result_valid && !result_stall) begin
        got = '{found: found, start: match_position, truncated: pattern_truncated};
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: found %0b position %0d truncated %0b",
                   $time, got.found, got.start, got.truncated);
        end else begin
          want = report_q.pop_front();
          if (got.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
          end
          if (got.start !== want.start) begin
            errors++;
            $display("%0t: match_position expected %0d, got %0d",
                     $time, want.start, got.start);
          end
          if (got.truncated !== want.truncated) begin
            errors++;
            $display("%0t: pattern_truncated expected %0b, got %0b",
                     $time, want.truncated, got.truncated);
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (kind == KIND_TEXT) begin
          if (scan_text(data_byte, last, want)) report_q = {report_q, want};
        end else begin
          // A pattern byte after close starts over.
          if (pat_closed) begin
            pat_len    = 0;
            trunc_flag = 1'b0;
            pat_closed = 1'b0;
            clear_text();
          end
          load_pattern(data_byte);
          if (last) pat_closed = 1'b1;
        end
      end
    end
    pending = report_q.size();
  end

endmodule

[bench/testbench.sv]
// Top of the KMP stream matcher bench: clock, reset, item stimulus, result stalls,
// watchdog and verdict. Depends on kmp_stream_matcher_core and kmp_match_checker.
`timescale 1ns / 100ps

module testbench;
  import kmp_bench_pkg::*;

  localparam int ITEM_TARGET   = 1450;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT    = 4000;  // cycles without any transfer
  localparam int SETTLE_CYCLES = 100;   // covers the longest fallback walk

  typedef logic [7:0] byte_seq_t [$];

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  logic        kind         = 1'b0;
  logic [7:0]  data_byte    = 8'h00;
  logic        last         = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        found;
  logic [31:0] match_position;
  logic        pattern_truncated;

  int          errors;
  int          pending;
  int          sent;
  bit          quiet;     // no random idling on either side
  bit          hold_req;  // ask the receiver for one long hold-off
  logic [7:0]  alpha [3]; // symbol set of the current sequence
  int          alpha_n;

  always #5 clk = ~clk;

  kmp_stream_matcher_core DUT (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .kind              (kind),
    .data_byte         (data_byte),
    .last              (last),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .found             (found),
    .match_position    (match_position),
    .pattern_truncated (pattern_truncated)
  );

  kmp_match_checker CHK (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .kind              (kind),
    .data_byte         (data_byte),
    .last              (last),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .found             (found),
    .match_position    (match_position),
    .pattern_truncated (pattern_truncated),
    .errors            (errors),
    .pending           (pending)
  );

  // Idle lengths: mostly from the short range, now and then from the long range.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [7:0] pick_sym();
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  // Draw a small alphabet so that matches and partial matches are common.
  function automatic void new_alphabet();
    alpha_n = $urandom_range(1, 3);
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
  endfunction

  // Mostly short patterns, a few long ones and a few past the store size.
  function automatic int pick_pattern_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 12);
    if (r < 95) return $urandom_range(13, STORE_DEPTH);
    return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
  endfunction

  // Periodic patterns give long fallback chains.
  function automatic byte_seq_t make_pattern(int len);
    byte_seq_t unit;
    byte_seq_t pat;
    int        ulen;
    if ($urandom_range(0, 99) < 40) begin
      ulen = $urandom_range(1, 3);
      for (int i = 0; i < ulen; i++) unit = {unit, pick_sym()};
      for (int i = 0; i < len; i++) pat = {pat, unit[i % ulen]};
    end else begin
      for (int i = 0; i < len; i++) pat = {pat, pick_sym()};
    end
    return pat;
  endfunction

  // Build text from whole copies, prefixes of the pattern and loose symbols.
  function automatic byte_seq_t make_text(byte_seq_t pat);
    byte_seq_t txt;
    int        tlen;
    int        cut;
    int        r;
    tlen = $urandom_range(4, 40);
    while (txt.size() < tlen) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        txt = {txt, pat};
      end else if (r < 60) begin
        cut = $urandom_range(1, pat.size());
        for (int i = 0; i < cut; i++) txt = {txt, pat[i]};
      end else begin
        txt = {txt, pick_sym()};
      end
    end
    return txt;
  endfunction

  // Offer one item at the falling edge and hold it until a transfer happens.
  task automatic send_byte(input item_kind_e k, input logic [7:0] b, input logic l);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    data_byte  <= b;
    last       <= l;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_seq(input item_kind_e k, input byte_seq_t s, input bit close);
    foreach (s[i]) send_byte(k, s[i], close && i == s.size() - 1);
  endtask

  // Stop offering until every expected result has been taken, then let the block settle.
  task automatic drain(input int extra);
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        result_stall <= 1'b0;
      end else if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        result_stall <= 1'b1;
        stall_left = pick_gap() - 1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    byte_seq_t  pat;
    byte_seq_t  junk;
    logic [7:0] sym;
    int         seq_no;
    bit         did_hold;
    bit         did_drain;
    seq_no    = 0;
    did_hold  = 1'b0;
    did_drain = 1'b0;

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part.
    // Text with no pattern loaded: the empty pattern only gives a none result.
    send_seq(KIND_TEXT, {8'h41}, 1'b1);
    // Extreme byte values; the second hit completes on the last text byte.
    send_seq(KIND_PATTERN, {8'h00, 8'hFF}, 1'b1);
    send_seq(KIND_TEXT, {8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1);
    // Same pattern kept, text with no occurrence.
    send_seq(KIND_TEXT, {8'hFF, 8'h00}, 1'b1);
    // New pattern after close; overlapping occurrences.
    send_seq(KIND_PATTERN, {8'h61, 8'h61}, 1'b1);
    send_seq(KIND_TEXT, {8'h61, 8'h61, 8'h61}, 1'b1);
    // Pattern left open: the first text byte closes it.
    send_seq(KIND_PATTERN, {8'h55, 8'hAA}, 1'b0);
    send_seq(KIND_TEXT, {8'h55, 8'hAA, 8'h55}, 1'b1);
    // Mismatch after a partial match: follow a fallback link.
    send_seq(KIND_PATTERN, {8'h61, 8'h61, 8'h62}, 1'b1);
    send_seq(KIND_TEXT, {8'h61, 8'h61, 8'h61, 8'h62}, 1'b1);

    // Random part: mostly well-formed pattern and text sequences with random content.
    pat = {8'h61};
    while (sent < ITEM_TARGET) begin
      if (!did_hold && sent >= 500) begin
        // Fill the block: every text byte hits while the receiver holds off.
        quiet = 1'b1;
        sym = 8'($urandom_range(0, 255));
        pat = {sym};
        send_seq(KIND_PATTERN, pat, 1'b1);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_byte(KIND_TEXT, sym, i == 39);
        quiet    = 1'b0;
        did_hold = 1'b1;
      end else if (!did_drain && sent >= 1000) begin
        drain(SETTLE_CYCLES);
        did_drain = 1'b1;
      end else if ($urandom_range(0, 99) < 6) begin
        // Noise: unrelated full-range bytes, texts not always closed.
        junk.delete();
        repeat ($urandom_range(1, 3)) junk = {junk, 8'($urandom_range(0, 255))};
        pat = junk;
        send_seq(KIND_PATTERN, pat, 1'($urandom_range(0, 1)));
        junk.delete();
        repeat ($urandom_range(3, 10)) junk = {junk, 8'($urandom_range(0, 255))};
        send_seq(KIND_TEXT, junk, 1'($urandom_range(0, 1)));
      end else begin
        new_alphabet();
        // A pattern in the first sequence overflows the store; if closed, the last mark is on a dropped byte.
        if (seq_no == 0 || $urandom_range(0, 99) < 85) begin
          pat = make_pattern(seq_no == 0 ? $urandom_range(STORE_DEPTH + 2, STORE_DEPTH + 6)
                                         : pick_pattern_len());
          send_seq(KIND_PATTERN, pat, $urandom_range(0, 9) != 0);
        end
        // An unclosed text runs on into the next one or is cut by a new pattern.
        repeat ($urandom_range(1, 3))
          send_seq(KIND_TEXT, make_text(pat), $urandom_range(0, 19) != 0);
      end
      seq_no++;
    end

    drain(SETTLE_CYCLES);
    if (errors == 0 && pending == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
